/* design/assert_macros.svh */
// Assertion macros shared by the burst detector modules.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define RBD_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition in one cycle that implies another in the next cycle.
`define RBD_IMPLY_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/rbd_pkg.sv */
// Shared constants and types for the restart burst detector.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package rbd_pkg;

  // Default sizes of the design.
  localparam int DEF_SLOTS     = 256;
  localparam int DEF_HISTORY   = 8;
  localparam int DEF_TIME_BITS = 32;

  // Fixed field widths.
  localparam int SLOT_IN_W = 8;
  localparam int KIND_W    = 2;
  localparam int CFG_W     = 32;
  localparam int THR_W     = 4;
  localparam int RCNT_W    = 4;
  localparam int TOTAL_W   = 32;

  // Action codes.
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DIE     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_OTHER   = 2'd3;

  // Configuration register indexes.
  localparam logic REG_WINDOW    = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] WINDOW_RESET    = 32'd300000;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 4'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // request accepted: latch its fields
    logic compare;  // history row is read: update and compare
    logic commit;   // count, write back and load the result
  } rbd_cmd_t;

endpackage

`default_nettype wire

/* design/restart_burst_detector.sv */
// Restart burst detector: takes one event at a time and returns one result per
// event. Each event goes through acceptance, a read of the slot's history row
// and flags from the on-chip memories, the window compare of every held stamp,
// and the count with write-back and loading of the result register; a stalled
// output holds back the last step. The history memory needs no clearing pass
// after reset: per-slot flags mark written slots.
// Depends on rbd_pkg, rbd_ctrl and rbd_dp.
`default_nettype none

module restart_burst_detector #(
  parameter int SLOTS     = rbd_pkg::DEF_SLOTS,
  parameter int HISTORY   = rbd_pkg::DEF_HISTORY,
  parameter int TIME_BITS = rbd_pkg::DEF_TIME_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [rbd_pkg::SLOT_IN_W-1:0]  entity_slot,
  input  wire logic [rbd_pkg::KIND_W-1:0]     action_kind,
  input  wire logic [TIME_BITS-1:0]           event_time,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                burst_flag,
  output logic [rbd_pkg::RCNT_W-1:0]          recent_count,
  output logic [rbd_pkg::TOTAL_W-1:0]         burst_total,
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic [rbd_pkg::CFG_W-1:0]      cfg_data
);
  import rbd_pkg::*;

  rbd_cmd_t cmd;

  // Sequencer.
  rbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Memories and arithmetic.
  rbd_dp #(
    .SLOTS     (SLOTS),
    .HISTORY   (HISTORY),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .entity_slot  (entity_slot),
    .action_kind  (action_kind),
    .event_time   (event_time),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .burst_flag   (burst_flag),
    .recent_count (recent_count),
    .burst_total  (burst_total)
  );

endmodule

`default_nettype wire

/* design/rbd_ctrl.sv */
// Controller of the restart burst detector: sequences one request at a time.
// Depends on rbd_pkg and assert_macros.svh.
`default_nettype none

module rbd_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output rbd_pkg::rbd_cmd_t    cmd
);
  import rbd_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_COMMIT
  } state_t;

  state_t state;
  logic   out_free;

  // The result register may be reloaded when empty or being emptied.
  assign out_free    = !out_valid || out_ready;
  assign in_ready    = (state == ST_IDLE);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.compare = (state == ST_CMP);
  assign cmd.commit  = (state == ST_COMMIT) && out_free;

  // State and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd.capture) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          state <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `RBD_IMPLY_NEXT(a_accept_reads, cmd.capture, state == ST_READ && !in_ready, "accept did not start a read")
  `RBD_ASSERT(a_commit_free, !(cmd.commit && out_valid && !out_ready), "commit over a held result")
  `RBD_IMPLY_NEXT(a_commit_shows, cmd.commit, out_valid && in_ready, "commit did not present a result")

endmodule

`default_nettype wire

/* design/rbd_dp.sv */
// Datapath of the restart burst detector: history memories, window compare,
// counting, burst total and configuration registers. Depends on rbd_pkg.
`default_nettype none

module rbd_dp #(
  parameter int SLOTS     = rbd_pkg::DEF_SLOTS,
  parameter int HISTORY   = rbd_pkg::DEF_HISTORY,
  parameter int TIME_BITS = rbd_pkg::DEF_TIME_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire rbd_pkg::rbd_cmd_t              cmd,
  input  wire logic [rbd_pkg::SLOT_IN_W-1:0]  entity_slot,
  input  wire logic [rbd_pkg::KIND_W-1:0]     action_kind,
  input  wire logic [TIME_BITS-1:0]           event_time,
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic [rbd_pkg::CFG_W-1:0]      cfg_data,
  output logic                                burst_flag,
  output logic [rbd_pkg::RCNT_W-1:0]          recent_count,
  output logic [rbd_pkg::TOTAL_W-1:0]         burst_total
);
  import rbd_pkg::*;

  `include "assert_macros.svh"

  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int POS_W   = $clog2(HISTORY);
  localparam int HLD_W   = $clog2(HISTORY + 1);
  localparam int META_W  = POS_W + HLD_W + 1;
  localparam int NOW_W   = (TIME_BITS < 32) ? TIME_BITS : 32;
  localparam int CMP_W   = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam int MAP_N   = 2 ** SLOT_IN_W;
  localparam logic [HLD_W-1:0] HOLD_MAX = HLD_W'(HISTORY);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(HISTORY - 1);

  typedef logic [HISTORY-1:0][TIME_BITS-1:0] row_t;

  // Configuration registers.
  logic [CFG_W-1:0] window_ms;
  logic [THR_W-1:0] burst_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms       <= WINDOW_RESET;
      burst_threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW:    window_ms       <= cfg_data;
        REG_THRESHOLD: burst_threshold <= cfg_data[THR_W-1:0];
        default:       window_ms       <= window_ms;
      endcase
    end
  end

  // Slot index folded into the slot range, worked out at elaboration.
  logic [SLOT_W-1:0] slot_map [MAP_N];

  for (genvar g = 0; g < MAP_N; g++) begin : g_map
    localparam int MAPPED = g % SLOTS;
    assign slot_map[g] = SLOT_W'(MAPPED);
  end

  // Captured request.
  logic [SLOT_W-1:0]    slot_r;
  logic [KIND_W-1:0]    kind_r;
  logic [TIME_BITS-1:0] now_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      slot_r <= slot_map[entity_slot];
      kind_r <= action_kind;
      now_r  <= TIME_BITS'(event_time[NOW_W-1:0]);
    end
  end

  // Per-slot memories: stamp row and position/count/die flags.
  row_t              row_mem  [SLOTS];
  logic [META_W-1:0] meta_mem [SLOTS];
  logic [SLOTS-1:0]  meta_vld;
  row_t              row_q;
  logic [META_W-1:0] meta_q;
  logic              vld_q;

  // Write-back values, built in the commit cycle.
  row_t              row_fin;
  logic [META_W-1:0] meta_fin;

  always_ff @(posedge clk) begin
    row_q  <= row_mem[slot_r];
    meta_q <= meta_mem[slot_r];
    if (cmd.commit) begin
      row_mem[slot_r]  <= row_fin;
      meta_mem[slot_r] <= meta_fin;
    end
  end

  // Flags of slots that were written; a slot never written reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      meta_vld <= '0;
      vld_q    <= 1'b0;
    end else begin
      vld_q <= meta_vld[slot_r];
      if (cmd.commit) begin
        meta_vld[slot_r] <= 1'b1;
      end
    end
  end

  // Record the new stamp and compare every held stamp with the window.
  logic [POS_W-1:0]  pos_rd;
  logic [HLD_W-1:0]  held_rd;
  logic              die_rd;
  logic              active;
  logic              record;
  row_t              row_upd;
  logic [HLD_W-1:0]  held_upd;
  logic [POS_W-1:0]  pos_upd;
  logic [HISTORY-1:0] hit_upd;
  logic [TIME_BITS-1:0] age;

  assign {pos_rd, held_rd, die_rd} = vld_q ? meta_q : '0;
  assign active = (kind_r == KIND_RESTART) || (kind_r == KIND_START) || (kind_r == KIND_DIE);
  assign record = (kind_r == KIND_RESTART) || ((kind_r == KIND_START) && die_rd);

  always_comb begin
    age      = '0;
    held_upd = (record && held_rd < HOLD_MAX) ? held_rd + 1'b1 : held_rd;
    pos_upd  = pos_rd;
    if (record) begin
      pos_upd = (pos_rd == POS_LAST) ? '0 : pos_rd + 1'b1;
    end
    for (int i = 0; i < HISTORY; i++) begin
      row_upd[i] = (record && pos_rd == POS_W'(i)) ? now_r : row_q[i];
      age        = now_r - row_upd[i];
      hit_upd[i] = active && (HLD_W'(i) < held_upd)
                   && (CMP_W'(age) < CMP_W'(window_ms));
    end
  end

  row_t               row_c;
  logic [HLD_W-1:0]   held_c;
  logic [POS_W-1:0]   pos_c;
  logic [HISTORY-1:0] hit_c;

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      row_c  <= row_upd;
      held_c <= held_upd;
      pos_c  <= pos_upd;
      hit_c  <= hit_upd;
    end
  end

  // Count the hits and decide on a burst.
  logic [5:0]       count;
  logic             burst;
  logic [TOTAL_W-1:0] bursts_seen;

  always_comb begin
    count = '0;
    for (int i = 0; i < HISTORY; i++) begin
      count = count + 6'(hit_c[i]);
    end
  end

  assign burst = active && (count >= 6'(burst_threshold));

  // A burst cuts the history back to the current stamp; the die flag follows
  // the action either way.
  always_comb begin
    row_fin  = row_c;
    meta_fin = {pos_c, held_c, kind_r == KIND_DIE};
    if (burst) begin
      row_fin[0] = now_r;
      meta_fin   = {POS_W'(1), HLD_W'(1), kind_r == KIND_DIE};
    end
  end

  // Burst total.
  always_ff @(posedge clk) begin
    if (rst) begin
      bursts_seen <= '0;
    end else if (cmd.commit && burst) begin
      bursts_seen <= bursts_seen + 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      burst_flag   <= burst;
      recent_count <= (count > 6'd15) ? 4'd15 : count[RCNT_W-1:0];
      burst_total  <= bursts_seen + TOTAL_W'(burst);
    end
  end

  `RBD_ASSERT(a_held_range, !cmd.commit || held_c <= HOLD_MAX, "held count beyond history")
  `RBD_IMPLY_NEXT(a_total_step, cmd.commit, bursts_seen == $past(bursts_seen) + TOTAL_W'($past(burst)), "burst total stepped wrongly")
  `RBD_IMPLY_NEXT(a_out_total, cmd.commit, burst_total == bursts_seen, "result total differs from register")

endmodule

`default_nettype wire

/* tb/restart_burst_detector_tb.sv */
// Testbench for restart burst detector: directed table, extremes, random events.
// Results are predicted per event and checked in order. Depends on rbd_pkg.
`default_nettype none

module restart_burst_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rbd_pkg::*;

  localparam int HIST = 8;
  localparam int NSLOTS = 256;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] entity_slot = '0;
  logic [1:0] action_kind = '0;
  logic [31:0] event_time = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic burst_flag;
  logic [3:0] recent_count;
  logic [31:0] burst_total;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  restart_burst_detector dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: a copy of each slot's history and the configuration.
  logic [31:0] stamp_ring [NSLOTS][HIST];
  logic [2:0]  ring_pos [NSLOTS];
  logic [3:0]  held [NSLOTS];
  logic        died [NSLOTS];
  logic [31:0] total_bursts;
  logic [31:0] window_len;
  logic [3:0]  threshold;

  typedef struct packed {
    logic        flag;
    logic [3:0]  count;
    logic [31:0] total;
  } burst_result_t;

  burst_result_t pending_results [$];
  int errors = 0;
  int checked = 0;
  int bursts_checked = 0;
  int send_idle = 0;
  int recv_stall = 0;
  // Per-slot time base used to keep random stamps near one another.
  logic [31:0] slot_clock [NSLOTS];

  task automatic report(input string what);
    errors++;
    $display("mismatch %0d: %s", errors, what);
  endtask

  function automatic burst_result_t predict_event(input logic [7:0] s, input logic [1:0] k,
                                                  input logic [31:0] now);
    burst_result_t r;
    int cnt;
    cnt = 0;
    r = '0;
    if (k != KIND_OTHER) begin
      if (k == KIND_RESTART || (k == KIND_START && died[s])) begin
        stamp_ring[s][ring_pos[s]] = now;
        ring_pos[s] = ring_pos[s] + 3'd1;
        if (held[s] < HIST) held[s] = held[s] + 4'd1;
      end
      for (int i = 0; i < HIST; i++)
        if (i < held[s] && (now - stamp_ring[s][i]) < window_len) cnt++;
      if (cnt >= threshold) begin
        r.flag = 1'b1;
        total_bursts = total_bursts + 32'd1;
        stamp_ring[s][0] = now;
        ring_pos[s] = 3'd1;
        held[s] = 4'd1;
      end
    end
    died[s] = (k == KIND_DIE);
    r.count = cnt[3:0];
    r.total = total_bursts;
    return r;
  endfunction

  // Check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      burst_result_t e;
      if (pending_results.size() == 0) begin
        report("result with nothing expected");
      end else begin
        e = pending_results.pop_front();
        checked++;
        if (e.flag) bursts_checked++;
        if (burst_flag !== e.flag)
          report($sformatf("burst_flag %0b want %0b", burst_flag, e.flag));
        if (recent_count !== e.count)
          report($sformatf("recent_count %0d want %0d", recent_count, e.count));
        if (burst_total !== e.total)
          report($sformatf("burst_total %0d want %0d", burst_total, e.total));
      end
    end
  end

  // Receiver stalls.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_WINDOW) window_len = val;
    else threshold = val[3:0];
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Present one request; when typed is clear the predictor gives the expectation.
  // The request line stays high from one request to the next unless the sender idles.
  task automatic send_event(input logic [7:0] s, input logic [1:0] k, input logic [31:0] t,
                            input bit typed, input burst_result_t want);
    burst_result_t p;
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    entity_slot <= s;
    action_kind <= k;
    event_time <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = predict_event(s, k, t);
    if (typed && p !== want)
      report($sformatf("table row slot %0d kind %0d: predictor disagrees", s, k));
    pending_results.push_back(typed ? want : p);
  endtask

  typedef struct {
    logic [7:0] s;
    logic [1:0] k;
    logic [31:0] t;
    bit typed;
    burst_result_t want;
  } table_row_t;

  table_row_t rows [] = '{
    // A first event after reset: one stamp, below the default threshold.
    '{8'd0, KIND_RESTART, 32'd0, 1, '{1'b0, 4'd1, 32'd0}},
    '{8'd0, KIND_RESTART, 32'd100, 1, '{1'b0, 4'd2, 32'd0}},
    '{8'd0, KIND_RESTART, 32'd200, 1, '{1'b1, 4'd3, 32'd1}},
    // Other action: nothing counted, total carried.
    '{8'd0, KIND_OTHER, 32'd300, 1, '{1'b0, 4'd0, 32'd1}},
    // Start without a prior die records nothing.
    '{8'd255, KIND_START, 32'hFFFF_FFFF, 1, '{1'b0, 4'd0, 32'd1}},
    '{8'd255, KIND_DIE, 32'hFFFF_FFFF, 1, '{1'b0, 4'd0, 32'd1}},
    '{8'd255, KIND_START, 32'hFFFF_FFFF, 1, '{1'b0, 4'd1, 32'd1}},
    // Wrap of the time stamp; a stamp after the event time never counts.
    '{8'd255, KIND_RESTART, 32'd5, 0, '0},
    '{8'd255, KIND_DIE, 32'd2, 0, '0},
    '{8'd255, KIND_START, 32'd400000, 0, '0},
    '{8'd128, KIND_DIE, 32'h8000_0000, 0, '0},
    '{8'd128, KIND_OTHER, 32'h8000_0001, 0, '0},
    '{8'd128, KIND_START, 32'h8000_0002, 0, '0}
  };

  int sent = 0;

  task automatic random_phase(input int n, input int si, input int rs);
    logic [7:0] s;
    logic [1:0] k;
    logic [31:0] t;
    send_idle = si;
    recv_stall = rs;
    for (int i = 0; i < n; i++) begin
      // Mostly a few busy slots with close stamps; sometimes any slot or time.
      s = ($urandom_range(3) != 0) ? 8'($urandom_range(7)) : 8'($urandom);
      k = 2'($urandom_range(9) < 5 ? KIND_RESTART : $urandom_range(3));
      if ($urandom_range(19) == 0) t = $urandom;
      else t = slot_clock[s] + $urandom_range(window_len > 32'd4000 ? 4000 : 200);
      slot_clock[s] = t;
      // Only touch slots whose history entries are defined: every unwritten
      // entry lies beyond held, so any slot is safe.
      send_event(s, k, t, 0, '0);
      sent++;
    end
  endtask

  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    for (int i = 0; i < NSLOTS; i++) begin
      ring_pos[i] = '0;
      held[i] = '0;
      died[i] = 1'b0;
      slot_clock[i] = $urandom;
      for (int j = 0; j < HIST; j++) stamp_ring[i][j] = '0;
    end
    total_bursts = '0;
    window_len = WINDOW_RESET;
    threshold = THRESHOLD_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    foreach (rows[i]) begin
      send_event(rows[i].s, rows[i].k, rows[i].t, rows[i].typed, rows[i].want);
      sent++;
    end
    drain();

    // Extremes: zero threshold bursts on every event; zero window counts nothing.
    write_reg(REG_THRESHOLD, 32'd0);
    write_reg(REG_WINDOW, 32'd0);
    send_event(8'd1, KIND_RESTART, 32'd10, 1, '{1'b1, 4'd0, total_bursts + 32'd1});
    send_event(8'd1, KIND_DIE, 32'd11, 0, '0);
    drain();
    write_reg(REG_WINDOW, 32'hFFFF_FFFF);
    write_reg(REG_THRESHOLD, 32'd15);
    for (int i = 0; i < 10; i++) send_event(8'd2, KIND_RESTART, 32'(i), 0, '0);
    sent += 12;
    drain();

    // Random phases under several settings and idling patterns.
    write_reg(REG_WINDOW, 32'd3000);
    write_reg(REG_THRESHOLD, 32'd3);
    random_phase(300, 0, 0);
    drain();
    write_reg(REG_WINDOW, 32'd1);
    write_reg(REG_THRESHOLD, 32'd1);
    random_phase(150, 83, 0);
    drain();
    write_reg(REG_WINDOW, 32'd8000);
    write_reg(REG_THRESHOLD, 32'd8);
    random_phase(300, 0, 83);
    drain();
    write_reg(REG_WINDOW, 32'hFFFF_FFFF);
    write_reg(REG_THRESHOLD, 32'd5);
    random_phase(300, 7, 7);
    drain();
    write_reg(REG_WINDOW, 32'd1500);
    write_reg(REG_THRESHOLD, 32'd2);
    random_phase(300, 30, 30);
    drain();

    $display("Sent %0d events; %0d results checked, %0d of them bursts.",
             sent, checked, bursts_checked);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

`default_nettype wire

/* restart_burst_detector.f */
+incdir+design
design/rbd_pkg.sv
design/rbd_ctrl.sv
design/rbd_dp.sv
design/restart_burst_detector.sv
tb/restart_burst_detector_tb.sv
